// ----- hw/rtl/perspective_vertex_project_top_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef PERSPECTIVE_VERTEX_PROJECT_TOP_DEFINES_SVH
`define PERSPECTIVE_VERTEX_PROJECT_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PVP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PVP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/pvp_pkg.sv -----
package pvp_pkg;

   typedef enum logic [2:0] {
      REG_CAM_POS_X = 3'd0,
      REG_CAM_POS_Y = 3'd1,
      REG_CAM_POS_Z = 3'd2,
      REG_VIEW_DIR  = 3'd3,
      REG_RIGHT_DIR = 3'd4,
      REG_UP_DIR    = 3'd5
   } reg_index_type;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;
   localparam int COMP_W     = 20;
   localparam int OFS_W      = 33;
   localparam int DOT_W      = 56;
   localparam int DIV_ITER   = 8;
   localparam int INV_W      = 32;
   localparam int NUM_W      = 51;

   localparam logic [31:0] CAM_X_RST  = 32'd204800;
   localparam logic [59:0] VIEW_RST   = 60'd786432;
   localparam logic [59:0] RIGHT_RST  = 60'd864691128455135232;
   localparam logic [59:0] UP_RST     = 60'd274877906944;

   typedef struct packed {
      logic signed [COMP_W-1:0] x;
      logic signed [COMP_W-1:0] y;
      logic signed [COMP_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic [31:0] cam_x;
      logic [31:0] cam_y;
      logic [31:0] cam_z;
      vec_type     view;
      vec_type     right;
      vec_type     up;
   } cfg_type;

   // Vertex stage tag, carried beside the data through the divider and scaler.
   typedef struct packed {
      logic                    vis;
      logic signed [DOT_W-1:0] px;
      logic signed [DOT_W-1:0] py;
   } tag_type;

   function automatic logic signed [15:0] sat16(input logic signed [71:0] v);
      if (v > 72'sd32767) begin
         sat16 = 16'sh7FFF;
      end else if (v < -72'sd32768) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[15:0];
      end
   endfunction

endpackage

// ----- hw/rtl/pvp_cfg_regs.sv -----
module pvp_cfg_regs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [pvp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pvp_pkg::CSR_DATA_W-1:0] csr_data,
   output pvp_pkg::cfg_type            cfg
);
   import pvp_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // vec_type packs x in the top bits; registers pack x in the low bits
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_CAM_POS_X: cfg_in.cam_x = csr_data[31:0];
            REG_CAM_POS_Y: cfg_in.cam_y = csr_data[31:0];
            REG_CAM_POS_Z: cfg_in.cam_z = csr_data[31:0];
            REG_VIEW_DIR:  cfg_in.view  = {csr_data[19:0], csr_data[39:20], csr_data[59:40]};
            REG_RIGHT_DIR: cfg_in.right = {csr_data[19:0], csr_data[39:20], csr_data[59:40]};
            REG_UP_DIR:    cfg_in.up    = {csr_data[19:0], csr_data[39:20], csr_data[59:40]};
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cam_x <= CAM_X_RST;
         cfg_ff.cam_y <= '0;
         cfg_ff.cam_z <= '0;
         cfg_ff.view  <= {VIEW_RST[19:0], VIEW_RST[39:20], VIEW_RST[59:40]};
         cfg_ff.right <= {RIGHT_RST[19:0], RIGHT_RST[39:20], RIGHT_RST[59:40]};
         cfg_ff.up    <= {UP_RST[19:0], UP_RST[39:20], UP_RST[59:40]};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// ----- hw/rtl/pvp_div_stage.sv -----
// One pipelined restoring-division step group: DIV_ITER quotient bits per stage.
module pvp_div_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [pvp_pkg::DOT_W-1:0] in_den,
   input  logic [pvp_pkg::NUM_W:0]   in_rem,
   input  logic [pvp_pkg::NUM_W-1:0] in_num,
   input  logic [pvp_pkg::NUM_W-1:0] in_quo,
   input  pvp_pkg::tag_type          in_tag,
   output logic                      out_valid,
   output logic [pvp_pkg::DOT_W-1:0] out_den,
   output logic [pvp_pkg::NUM_W:0]   out_rem,
   output logic [pvp_pkg::NUM_W-1:0] out_num,
   output logic [pvp_pkg::NUM_W-1:0] out_quo,
   output pvp_pkg::tag_type          out_tag
);
   import pvp_pkg::*;

   logic                 valid_ff;
   logic [DOT_W-1:0]     den_ff;
   logic [NUM_W:0]       rem_ff, rem_in;
   logic [NUM_W-1:0]     num_ff, num_in, quo_ff, quo_in;
   tag_type              tag_ff;

   always_comb begin
      logic [NUM_W+1:0] trial;
      rem_in = in_rem;
      num_in = in_num;
      quo_in = in_quo;
      for (int i = 0; i < DIV_ITER; i++) begin
         trial = {rem_in, num_in[NUM_W-1]} - {1'b0, in_den[NUM_W:0]};
         num_in = {num_in[NUM_W-2:0], 1'b0};
         if (!trial[NUM_W+1]) begin
            rem_in = trial[NUM_W:0];
            quo_in = {quo_in[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_in[NUM_W-1:0], in_num[NUM_W-1-i]};
            quo_in = {quo_in[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff <= in_den;
         rem_ff <= rem_in;
         num_ff <= num_in;
         quo_ff <= quo_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_den   = den_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_quo   = quo_ff;
   assign out_tag   = tag_ff;
endmodule

// ----- hw/rtl/perspective_vertex_project_top.sv -----
// Channel  | Ports                                   | Direction
// request  | req_valid/ready, req_vertex_x/y/z       | in
// result   | rsp_valid/ready, rsp_screen_x/y, ...    | out
// config   | csr_write, csr_index, csr_data          | in
// One request per cycle when the result side keeps up; the inverse depth comes
// from the seven-stage pipelined divider.
// Synchronous active-high reset clears all stage valid bits and loads the
// default camera. A stall on rsp_ready freezes every stage at once.
module perspective_vertex_project_top #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 200
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [31:0]             req_vertex_x,
   input  logic signed [31:0]             req_vertex_y,
   input  logic signed [31:0]             req_vertex_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [15:0]             rsp_screen_x,
   output logic signed [15:0]             rsp_screen_y,
   output logic [31:0]                    rsp_inv_depth,
   output logic                           rsp_visible,
   input  logic                           csr_write,
   input  logic [pvp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pvp_pkg::CSR_DATA_W-1:0] csr_data
);
   import pvp_pkg::*;

   localparam int NDIV = (NUM_W + DIV_ITER - 1) / DIV_ITER;
   localparam int SW_W = $clog2(SCREEN_WIDTH + 1) + 1;
   localparam int SH_W = $clog2(SCREEN_HEIGHT + 1) + 1;

   cfg_type cfg;
   logic    adv;

   pvp_cfg_regs u_cfg (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .cfg
   );

   // whole pipe advances together; output register empties or is taken
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // s1: offsets
   logic                     s1_v_ff;
   logic signed [OFS_W-1:0]  r_ff [3];
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0] <= OFS_W'(req_vertex_x) - OFS_W'($signed(cfg.cam_x));
         r_ff[1] <= OFS_W'(req_vertex_y) - OFS_W'($signed(cfg.cam_y));
         r_ff[2] <= OFS_W'(req_vertex_z) - OFS_W'($signed(cfg.cam_z));
      end
   end

   // s2: products (33x20 each)
   logic                    s2_v_ff;
   logic signed [53:0]      pd_ff [3], pr_ff [3], pu_ff [3];
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (adv) s2_v_ff <= s1_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         pd_ff[0] <= 54'(r_ff[0] * cfg.view.x);
         pd_ff[1] <= 54'(r_ff[1] * cfg.view.y);
         pd_ff[2] <= 54'(r_ff[2] * cfg.view.z);
         pr_ff[0] <= 54'(r_ff[0] * cfg.right.x);
         pr_ff[1] <= 54'(r_ff[1] * cfg.right.y);
         pr_ff[2] <= 54'(r_ff[2] * cfg.right.z);
         pu_ff[0] <= 54'(r_ff[0] * cfg.up.x);
         pu_ff[1] <= 54'(r_ff[1] * cfg.up.y);
         pu_ff[2] <= 54'(r_ff[2] * cfg.up.z);
      end
   end

   // s3: dot sums
   logic                    s3_v_ff;
   logic signed [DOT_W-1:0] d_ff, px_ff, py_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (adv) s3_v_ff <= s2_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff  <= DOT_W'(pd_ff[0]) + DOT_W'(pd_ff[1]) + DOT_W'(pd_ff[2]);
         px_ff <= DOT_W'(pr_ff[0]) + DOT_W'(pr_ff[1]) + DOT_W'(pr_ff[2]);
         py_ff <= DOT_W'(pu_ff[0]) + DOT_W'(pu_ff[1]) + DOT_W'(pu_ff[2]);
      end
   end

   // divider chain: floor(2^50 / d); d>2^50 gives zero naturally
   logic                dv  [NDIV+1];
   logic [DOT_W-1:0]    dden[NDIV+1];
   logic [NUM_W:0]      drem[NDIV+1];
   logic [NUM_W-1:0]    dnum[NDIV+1];
   logic [NUM_W-1:0]    dquo[NDIV+1];
   tag_type             dtag[NDIV+1];
   logic                vis0, big0;

   // the chain shifts in NDIV*DIV_ITER dividend bits; leading ones are zero
   assign vis0    = !d_ff[DOT_W-1] && (d_ff != '0);
   assign big0    = |d_ff[DOT_W-2:NUM_W];
   assign dv[0]   = s3_v_ff;
   assign dden[0] = (vis0 && !big0) ? d_ff : {1'b0, {(DOT_W-1){1'b1}}};
   assign drem[0] = '0;
   assign dnum[0] = NUM_W'(64'd1 << 50) >> (NDIV * DIV_ITER - NUM_W);
   assign dquo[0] = '0;
   assign dtag[0] = '{vis: vis0, px: px_ff, py: py_ff};

   for (genvar g = 0; g < NDIV; g++) begin : g_div
      pvp_div_stage u_st (
         .clock, .reset, .adv,
         .in_valid(dv[g]), .in_den(dden[g]), .in_rem(drem[g]), .in_num(dnum[g]),
         .in_quo(dquo[g]), .in_tag(dtag[g]),
         .out_valid(dv[g+1]), .out_den(dden[g+1]), .out_rem(drem[g+1]),
         .out_num(dnum[g+1]), .out_quo(dquo[g+1]), .out_tag(dtag[g+1])
      );
   end

   // s4: saturated inverse depth, view.axis constants
   logic               s4_v_ff, s4_vis_ff;
   logic [INV_W-1:0]   t_ff;
   logic [DOT_W-1:0]   mx_ff, my_ff;
   logic               nx_ff, ny_ff;
   logic signed [42:0] qx_ff, qy_ff;
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (adv) s4_v_ff <= dv[NDIV];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_vis_ff <= dtag[NDIV].vis;
         t_ff  <= (|dquo[NDIV][NUM_W-1:INV_W]) ? '1 : dquo[NDIV][INV_W-1:0];
         nx_ff <= dtag[NDIV].px[DOT_W-1];
         ny_ff <= dtag[NDIV].py[DOT_W-1];
         mx_ff <= dtag[NDIV].px[DOT_W-1] ? DOT_W'(-dtag[NDIV].px) : dtag[NDIV].px;
         my_ff <= dtag[NDIV].py[DOT_W-1] ? DOT_W'(-dtag[NDIV].py) : dtag[NDIV].py;
         qx_ff <= 43'(cfg.view.x * cfg.right.x) + 43'(cfg.view.y * cfg.right.y)
                + 43'(cfg.view.z * cfg.right.z);
         qy_ff <= 43'(cfg.view.x * cfg.up.x) + 43'(cfg.view.y * cfg.up.y)
                + 43'(cfg.view.z * cfg.up.z);
      end
   end

   // s5: partial products |P| split at bit 28 (28x32 and 28x32)
   logic               s5_v_ff, s5_vis_ff, s5_nx_ff, s5_ny_ff;
   logic [INV_W-1:0]   s5_t_ff;
   logic [59:0]        xl_ff, xh_ff, yl_ff, yh_ff;
   logic signed [42:0] s5_qx_ff, s5_qy_ff;
   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else if (adv) s5_v_ff <= s4_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s5_vis_ff <= s4_vis_ff;
         s5_t_ff <= t_ff;
         s5_nx_ff <= nx_ff;
         s5_ny_ff <= ny_ff;
         xl_ff <= 60'(mx_ff[27:0]) * 60'(t_ff);
         xh_ff <= 60'(mx_ff[DOT_W-1:28]) * 60'(t_ff);
         yl_ff <= 60'(my_ff[27:0]) * 60'(t_ff);
         yh_ff <= 60'(my_ff[DOT_W-1:28]) * 60'(t_ff);
         s5_qx_ff <= qx_ff;
         s5_qy_ff <= qy_ff;
      end
   end

   // s6: A = sign * min(prod >> 14, 2^50), then A - Q
   logic                s6_v_ff, s6_vis_ff;
   logic [INV_W-1:0]    s6_t_ff;
   logic signed [52:0]  ex_ff, ey_ff;
   logic [88:0]         fx, fy;
   logic [50:0]         ax, ay;
   assign fx = 89'(xl_ff) + (89'(xh_ff) << 28);
   assign fy = 89'(yl_ff) + (89'(yh_ff) << 28);
   assign ax = (|fx[88:64]) ? 51'(64'd1 << 50) : 51'(fx[63:14] );
   assign ay = (|fy[88:64]) ? 51'(64'd1 << 50) : 51'(fy[63:14]);
   always_ff @(posedge clock) begin
      if (reset) s6_v_ff <= 1'b0;
      else if (adv) s6_v_ff <= s5_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s6_vis_ff <= s5_vis_ff;
         s6_t_ff <= s5_t_ff;
         ex_ff <= (s5_nx_ff ? -53'(ax) : 53'(ax)) - 53'(s5_qx_ff);
         ey_ff <= (s5_ny_ff ? -53'(ay) : 53'(ay)) - 53'(s5_qy_ff);
      end
   end

   // s7: scale; s8: truncate and saturate into output register
   logic                s7_v_ff, s7_vis_ff;
   logic [INV_W-1:0]    s7_t_ff;
   logic signed [71:0]  sx_ff, sy_ff;
   always_ff @(posedge clock) begin
      if (reset) s7_v_ff <= 1'b0;
      else if (adv) s7_v_ff <= s6_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s7_vis_ff <= s6_vis_ff;
         s7_t_ff <= s6_t_ff;
         sx_ff <= 72'(ex_ff) * 72'($signed(SW_W'(SCREEN_WIDTH)));
         sy_ff <= 72'(ey_ff) * 72'($signed(SH_W'(SCREEN_HEIGHT)));
      end
   end

   logic signed [71:0] tx, ty;
   assign tx = sx_ff[71] ? -72'((-sx_ff) >>> 36) : (sx_ff >>> 36);
   assign ty = sy_ff[71] ? -72'((-sy_ff) >>> 36) : (sy_ff >>> 36);

   logic               o_v_ff, o_vis_ff;
   logic signed [15:0] o_x_ff, o_y_ff;
   logic [31:0]        o_t_ff;
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else if (adv) o_v_ff <= s7_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         o_vis_ff <= s7_vis_ff;
         o_t_ff   <= s7_vis_ff ? s7_t_ff : '0;
         o_x_ff   <= s7_vis_ff ? sat16(tx + 72'(SCREEN_WIDTH / 2)) : '0;
         o_y_ff   <= s7_vis_ff ? sat16(72'(SCREEN_HEIGHT / 2) - ty) : '0;
      end
   end

   assign rsp_valid     = o_v_ff;
   assign rsp_visible   = o_vis_ff;
   assign rsp_inv_depth = o_t_ff;
   assign rsp_screen_x  = o_x_ff;
   assign rsp_screen_y  = o_y_ff;
endmodule

// ----- hw/rtl/pvp_checker.sv -----
`include "perspective_vertex_project_top_defines.svh"
module pvp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_screen_x,
   input logic [15:0] rsp_screen_y,
   input logic [31:0] rsp_inv_depth,
   input logic        rsp_visible
);
   `PVP_ASSERT_IMP(a_hidden_zero, clock, reset, rsp_valid && !rsp_visible, rsp_screen_x == 16'd0 && rsp_screen_y == 16'd0 && rsp_inv_depth == 32'd0, "hidden result not zero")
   `PVP_ASSERT_IMP(a_ready_free, clock, reset, !rsp_valid, req_ready, "request side blocked with empty output")
   `PVP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_inv_depth), "stalled result changed")
   `PVP_ASSERT_NXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid, "waiting request withdrawn")
endmodule

bind perspective_vertex_project_top pvp_checker u_pvp_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_screen_x, .rsp_screen_y, .rsp_inv_depth, .rsp_visible
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import pvp_pkg::*;

   localparam int SCR_W = 320;
   localparam int SCR_H = 200;
   localparam int LIMIT = 400000;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic [31:0]        inv_depth;
      logic               visible;
   } proj_type;

   class projection_board;
      logic [31:0] cam [3];
      logic [59:0] view_v, right_v, up_v;
      proj_type    pending [$];
      int          errors;

      function new();
         cam[0] = CAM_X_RST; cam[1] = 0; cam[2] = 0;
         view_v = VIEW_RST; right_v = RIGHT_RST; up_v = UP_RST;
         errors = 0;
      endfunction

      function void set_reg(int idx, logic [59:0] val);
         case (idx)
            REG_CAM_POS_X: cam[0] = val[31:0];
            REG_CAM_POS_Y: cam[1] = val[31:0];
            REG_CAM_POS_Z: cam[2] = val[31:0];
            REG_VIEW_DIR:  view_v = val;
            REG_RIGHT_DIR: right_v = val;
            REG_UP_DIR:    up_v = val;
            default: ;
         endcase
      endfunction

      function longint part(logic [59:0] p, int i);
         logic signed [19:0] c;
         c = p[20*i +: 20];
         return longint'(c);
      endfunction

      function longint dot_ofs(longint r0, longint r1, longint r2, logic [59:0] p);
         return r0 * part(p, 0) + r1 * part(p, 1) + r2 * part(p, 2);
      endfunction

      function longint dot_axes(logic [59:0] a, logic [59:0] b);
         return part(a, 0) * part(b, 0) + part(a, 1) * part(b, 1) + part(a, 2) * part(b, 2);
      endfunction

      function longint axis_term(longint p, logic [63:0] t, longint q, longint scale);
         logic [127:0] prod;
         logic [63:0]  m, mag;
         longint       a, s;
         m = (p < 0) ? -p : p;
         prod = {64'd0, m} * {64'd0, t};
         mag = ((prod >> 14) > (128'd1 << 50)) ? (64'd1 << 50) : prod[77:14];
         a = (p < 0) ? -longint'(mag) : longint'(mag);
         s = scale * (a - q);
         return s / 64'sd68719476736;
      endfunction

      function logic signed [15:0] clip16(longint v);
         if (v > 32767) return 16'sh7FFF;
         if (v < -32768) return 16'sh8000;
         return v[15:0];
      endfunction

      function void note_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
         longint      r0, r1, r2, d, tx, ty;
         logic [63:0] t;
         proj_type    e;
         r0 = longint'($signed(vx)) - longint'($signed(cam[0]));
         r1 = longint'($signed(vy)) - longint'($signed(cam[1]));
         r2 = longint'($signed(vz)) - longint'($signed(cam[2]));
         d = dot_ofs(r0, r1, r2, view_v);
         e = '0;
         if (d > 0) begin
            t = (64'd1 << 50) / d;
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            tx = axis_term(dot_ofs(r0, r1, r2, right_v), t, dot_axes(view_v, right_v), SCR_W);
            ty = axis_term(dot_ofs(r0, r1, r2, up_v), t, dot_axes(view_v, up_v), SCR_H);
            e.screen_x = clip16(tx + SCR_W / 2);
            e.screen_y = clip16(SCR_H / 2 - ty);
            e.inv_depth = t[31:0];
            e.visible = 1'b1;
         end
         pending.push_back(e);
      endfunction

      function void check_result(proj_type got);
         proj_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %p", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.screen_x !== e.screen_x) begin
            $error("screen_x expected %0d actual %0d", e.screen_x, got.screen_x);
            errors++;
         end
         if (got.screen_y !== e.screen_y) begin
            $error("screen_y expected %0d actual %0d", e.screen_y, got.screen_y);
            errors++;
         end
         if (got.inv_depth !== e.inv_depth) begin
            $error("inv_depth expected %0h actual %0h", e.inv_depth, got.inv_depth);
            errors++;
         end
         if (got.visible !== e.visible) begin
            $error("visible expected %0b actual %0b", e.visible, got.visible);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_ready;
   logic signed [31:0]    req_vertex_x = 0, req_vertex_y = 0, req_vertex_z = 0;
   logic                  rsp_valid;
   logic                  rsp_ready = 0;
   logic signed [15:0]    rsp_screen_x, rsp_screen_y;
   logic [31:0]           rsp_inv_depth;
   logic                  rsp_visible;
   logic                  csr_write = 0;
   logic [CSR_IDX_W-1:0]  csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_data = 0;

   projection_board board = new();
   bit  idle_on = 1;
   bit  hold_req = 0;
   int  cycles = 0;

   perspective_vertex_project_top u_top (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[perspective_vertex_project_top] ERROR");
         $finish;
      end
   end

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_result({rsp_screen_x, rsp_screen_y, rsp_inv_depth, rsp_visible});
         if (hold_req && hold == 0) hold = 300;
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(99) < 21);
         end
      end
   end

   task automatic send_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      while (idle_on && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_x <= vx;
      req_vertex_y <= vy;
      req_vertex_z <= vz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_vertex(vx, vy, vz);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(int idx, logic [59:0] val);
      csr_write <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_data <= val;
      @(posedge clock);
      board.set_reg(idx, val);
   endtask

   task automatic end_writes();
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [59:0] pack3(logic [19:0] x, logic [19:0] y, logic [19:0] z);
      return {z, y, x};
   endfunction

   function automatic logic [19:0] rand_comp();
      case ($urandom_range(3))
         0: return 20'h40000;
         1: return 20'hC0000;
         2: return 20'($urandom_range(20'hFFFFF));
         default: return 20'($urandom_range(20'h7FF)) - 20'h400;
      endcase
   endfunction

   function automatic logic [31:0] rand_offset();
      logic [31:0] v;
      v = $urandom() >> $urandom_range(31);
      return $urandom_range(1) ? v : -v;
   endfunction

   task automatic random_vertex();
      if ($urandom_range(9) < 2) begin
         send_vertex($urandom(), $urandom(), $urandom());
      end else begin
         send_vertex(board.cam[0] + rand_offset(), board.cam[1] + rand_offset(),
                     board.cam[2] + rand_offset());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default camera at x=800 looking down -x
      send_vertex(0, 0, 0);
      send_vertex(32'sd204800, 0, 0);
      send_vertex(32'sd204799, 0, 0);
      send_vertex(32'sd204800 + 256, 0, 0);
      send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_vertex(32'sd204799, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_vertex(32'sd204799, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_vertex(32'sd102400, 32'sd2560, -32'sd2560);
      send_vertex(32'sd100000, -32'sd25600, 32'sd25600);
      send_vertex(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
      drain();

      // ignored indexes, then extreme registers
      write_reg(6, '1);
      write_reg(7, '1);
      write_reg(REG_CAM_POS_X, 32'h8000_0000);
      write_reg(REG_CAM_POS_Y, 32'h7FFF_FFFF);
      write_reg(REG_CAM_POS_Z, 32'h8000_0000);
      write_reg(REG_VIEW_DIR, pack3(20'h80000, 20'h7FFFF, 20'h80000));
      write_reg(REG_RIGHT_DIR, pack3(20'h7FFFF, 20'h80000, 20'h7FFFF));
      write_reg(REG_UP_DIR, pack3(20'h80000, 20'h80000, 20'h7FFFF));
      end_writes();
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_vertex(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
      send_vertex(0, 0, 0);
      send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 8) begin
            write_reg(REG_CAM_POS_X, CAM_X_RST);
            write_reg(REG_CAM_POS_Y, 0);
            write_reg(REG_CAM_POS_Z, 0);
            write_reg(REG_VIEW_DIR, VIEW_RST);
            write_reg(REG_RIGHT_DIR, RIGHT_RST);
            write_reg(REG_UP_DIR, UP_RST);
         end else begin
            write_reg(REG_CAM_POS_X, $urandom_range(1) ? $urandom() : rand_offset());
            write_reg(REG_CAM_POS_Y, $urandom_range(1) ? $urandom() : rand_offset());
            write_reg(REG_CAM_POS_Z, $urandom_range(1) ? $urandom() : rand_offset());
            write_reg(REG_VIEW_DIR, pack3(rand_comp(), rand_comp(), rand_comp()));
            write_reg(REG_RIGHT_DIR, pack3(rand_comp(), rand_comp(), rand_comp()));
            write_reg(REG_UP_DIR, pack3(rand_comp(), rand_comp(), rand_comp()));
         end
         end_writes();
         idle_on = (ph != 4);
         for (int i = 0; i < 52; i++) begin
            if (ph == 2 && i == 5) hold_req = 1;
            if (ph == 2 && i == 6) hold_req = 0;
            if (ph == 6 && i == 26) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (board.pending.size() != 0) @(posedge clock);
            end
            random_vertex();
         end
         drain();
      end
      idle_on = 1;

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("[perspective_vertex_project_top] OK");
      end else begin
         $display("[perspective_vertex_project_top] ERROR");
      end
      $finish;
   end
endmodule
